// ===== hw/rtl/rmu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmu_pkg
// Shared types, constants and helpers of the regret matching unit.
// ----------------------------------------------------------------------------
package rmu_pkg;

	// Number of action slots on the request and result channels.
	localparam int IO_SLOTS = 6;

	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Request modes.
	typedef enum logic [1:0] {
		MODE_REGRET  = 2'd0,
		MODE_AVERAGE = 2'd1,
		MODE_CURRENT = 2'd2,
		MODE_READAVG = 2'd3
	} mode_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ACC,
		ST_SUM,
		ST_DIVST,
		ST_DIV,
		ST_DONE
	} state_t;

	// Control bundle broadcast to every lane.
	typedef struct packed {
		logic       mul1;
		logic       mul2;
		logic       acc;
		logic       div_start;
		logic       div_step;
		mode_t      mode;
		logic [1:0] shift;
	} lane_ctrl_t;

	// Uniform probability 65536 / n, truncated, for n in 1..6.
	function automatic logic [16:0] uniform_q16(input logic [2:0] n);
		logic [16:0] r;
		unique case (n)
			3'd1: r = 17'd65536;
			3'd2: r = 17'd32768;
			3'd3: r = 17'd21845;
			3'd4: r = 17'd16384;
			3'd5: r = 17'd13107;
			3'd6: r = 17'd10922;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/rmu_req_if.sv =====
// ----------------------------------------------------------------------------
// rmu_req_if
// Request channel: mode, iteration weight, reach and six action values.
// ----------------------------------------------------------------------------
interface rmu_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [19:0]        iteration;
	logic [15:0]        reach;
	logic signed [31:0] value_0;
	logic signed [31:0] value_1;
	logic signed [31:0] value_2;
	logic signed [31:0] value_3;
	logic signed [31:0] value_4;
	logic signed [31:0] value_5;

	modport source (output valid, mode, iteration, reach,
		value_0, value_1, value_2, value_3, value_4, value_5, input ready);
	modport sink (input valid, mode, iteration, reach,
		value_0, value_1, value_2, value_3, value_4, value_5, output ready);
endinterface

// ===== hw/rtl/rmu_res_if.sv =====
// ----------------------------------------------------------------------------
// rmu_res_if
// Result channel: six probabilities and an error flag.
// ----------------------------------------------------------------------------
interface rmu_res_if;
	logic        valid;
	logic        ready;
	logic [16:0] prob_0;
	logic [16:0] prob_1;
	logic [16:0] prob_2;
	logic [16:0] prob_3;
	logic [16:0] prob_4;
	logic [16:0] prob_5;
	logic        error;

	modport source (output valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5,
		error, input ready);
	modport sink (input valid, prob_0, prob_1, prob_2, prob_3, prob_4, prob_5,
		error, output ready);
endinterface

// ===== hw/rtl/rmu_lane.sv =====
// ----------------------------------------------------------------------------
// rmu_lane
// One action slot: regret and strategy accumulators, the weight multiplier
// chain and a radix-2 fraction divider for normalization.
// ----------------------------------------------------------------------------
module rmu_lane
	import rmu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lane_ctrl_t         ctrl,
	input  logic               active,
	input  logic [19:0]        iteration,
	input  logic [15:0]        reach,
	input  logic signed [31:0] value,
	input  logic signed [63:0] sum,
	output logic signed [63:0] term,
	output logic [16:0]        prob
);

	logic signed [63:0] regret_q;
	logic signed [63:0] strategy_q;
	logic signed [52:0] prod_s1;
	logic signed [63:0] addend_s2;
	logic [64:0]        rem_q;
	logic [15:0]        quo_q;
	logic               zero_q;
	logic               one_q;

	logic signed [20:0] op_a;
	logic signed [52:0] prod_a;
	logic [52:0]        prod_abs;
	logic [32:0]        mag;
	logic signed [33:0] q_term;
	logic signed [54:0] prod_b;
	logic signed [63:0] acc_old;
	logic signed [64:0] acc_sum;
	logic signed [63:0] acc_new;
	logic signed [63:0] shifted;
	logic [64:0]        rem_dbl;
	logic [64:0]        sum_ext;

	// First multiply: iteration times delta, or reach times probability.
	always_comb begin
		if (ctrl.mode == MODE_REGRET) begin
			op_a = $signed({1'b0, iteration});
		end else begin
			op_a = $signed({5'b0, reach});
		end
		prod_a = 53'(op_a * value);
	end

	// Second stage: truncate the strategy term toward zero and weight it.
	always_comb begin
		prod_abs = prod_s1[52] ? 53'(-prod_s1) : 53'(prod_s1);
		mag      = prod_abs[47:15];
		q_term   = prod_s1[52] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		prod_b   = 55'($signed({1'b0, iteration}) * q_term);
	end

	// Saturating accumulate into the selected total.
	always_comb begin
		acc_old = (ctrl.mode == MODE_REGRET) ? regret_q : strategy_q;
		acc_sum = {acc_old[63], acc_old} + {addend_s2[63], addend_s2};
		if (acc_sum[64] != acc_sum[63]) begin
			acc_new = acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			acc_new = acc_sum[63:0];
		end
	end

	// Normalization term and its floor shift.
	always_comb begin
		if (ctrl.mode == MODE_CURRENT) begin
			term = regret_q[63] ? 64'sd0 : regret_q;
		end else begin
			term = strategy_q;
		end
		shifted = term >>> ctrl.shift;
		rem_dbl = {rem_q[63:0], 1'b0};
		sum_ext = {1'b0, sum};
	end

	// Accumulators are control state and clear at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regret_q   <= '0;
			strategy_q <= '0;
		end else if (ctrl.acc && active) begin
			if (ctrl.mode == MODE_REGRET) begin
				regret_q <= acc_new;
			end else begin
				strategy_q <= acc_new;
			end
		end
	end

	// Multiplier pipeline and divider datapath.
	always_ff @(posedge clk) begin
		if (ctrl.mul1) begin
			prod_s1 <= prod_a;
		end
		if (ctrl.mul2) begin
			if (ctrl.mode == MODE_REGRET) begin
				addend_s2 <= 64'(prod_s1);
			end else begin
				addend_s2 <= 64'(prod_b);
			end
		end
		if (ctrl.div_start) begin
			zero_q <= (shifted <= 64'sd0);
			one_q  <= (shifted >= sum);
			rem_q  <= {1'b0, shifted};
			quo_q  <= '0;
		end else if (ctrl.div_step) begin
			if (rem_dbl >= sum_ext) begin
				rem_q <= rem_dbl - sum_ext;
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rem_dbl;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign prob = zero_q ? 17'd0 : (one_q ? ONE_Q16 : {1'b0, quo_q});

endmodule

// ===== hw/rtl/rmu_merge.sv =====
// ----------------------------------------------------------------------------
// rmu_merge
// Combines the lane terms into one sum, stepping the right shift until the
// running sum stays inside the signed 64-bit range.
// ----------------------------------------------------------------------------
module rmu_merge
	import rmu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         n,
	input  logic signed [63:0] terms [IO_SLOTS],
	output logic signed [63:0] sum,
	output logic [1:0]         shift,
	output logic               done
);

	logic               busy_q;
	logic               done_q;
	logic [2:0]         idx_q;
	logic [1:0]         shift_q;
	logic signed [63:0] acc_q;

	logic signed [63:0] t_sel;
	logic signed [63:0] t_shift;
	logic signed [64:0] t_sum;
	logic               ovf;

	// One term per cycle through a single wide adder.
	always_comb begin
		t_sel   = (32'(idx_q) < IO_SLOTS) ? terms[idx_q] : 64'sd0;
		t_shift = t_sel >>> shift_q;
		t_sum   = {acc_q[63], acc_q} + {t_shift[63], t_shift};
		ovf     = t_sum[64] != t_sum[63];
	end

	// Sequencer: restart with a larger shift on overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			shift_q <= '0;
			acc_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			idx_q   <= '0;
			shift_q <= '0;
			acc_q   <= '0;
		end else if (busy_q) begin
			if (ovf) begin
				shift_q <= shift_q + 2'd1;
				idx_q   <= '0;
				acc_q   <= '0;
			end else begin
				acc_q <= t_sum[63:0];
				idx_q <= idx_q + 3'd1;
				if (idx_q + 3'd1 == n) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sum   = acc_q;
	assign shift = shift_q;
	assign done  = done_q;

endmodule

// ===== hw/rtl/regret_matching_unit.sv =====
// ----------------------------------------------------------------------------
// regret_matching_unit
// Linear-weighted regret matching for one decision point.
// ----------------------------------------------------------------------------
// One request is handled at a time and always yields one result. Update
// requests (modes 0 and 1) pass two multiplier stages and a saturating add
// in every active lane at once before their result goes to the output
// register. A mode 1 request whose reach is above one skips the lanes and
// goes straight to the done state. Read requests (modes 2 and 3) run the
// merge stage, which adds one lane term per cycle and restarts its sum
// with a larger shift at most three times; then all lanes run their
// 16-step fraction dividers in parallel. A sum that is not positive skips
// the dividers and gives the uniform result. A new request is taken as
// soon as the previous result is in the output register.
// ----------------------------------------------------------------------------
module regret_matching_unit
	import rmu_pkg::*;
#(
	parameter int MAX_ACTIONS = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	rmu_req_if.sink    item,
	rmu_res_if.source  result,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata
);

	state_t             state_q, state_d;
	logic [2:0]         count_q;
	mode_t              mode_q;
	logic [19:0]        iter_q;
	logic [15:0]        reach_q;
	logic signed [31:0] val_q [IO_SLOTS];
	logic [2:0]         n_q;
	logic [3:0]         step_q;
	logic               err_q;
	logic               unif_q;
	logic               out_valid_q;
	logic [16:0]        prob_q [IO_SLOTS];
	logic               error_q;

	lane_ctrl_t         ctrl;
	logic               accept;
	logic               merge_start;
	logic [2:0]         n_eff;
	logic signed [63:0] terms [IO_SLOTS];
	logic [16:0]        lane_prob [IO_SLOTS];
	logic signed [63:0] sum;
	logic [1:0]         shift;
	logic               merge_done;
	logic               load;

	assign accept = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	// Clamp the action count to 1..MAX_ACTIONS.
	always_comb begin
		if (count_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (count_q > 3'(MAX_ACTIONS)) begin
			n_eff = 3'(MAX_ACTIONS);
		end else begin
			n_eff = count_q;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd6;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(item.mode);
			iter_q   <= item.iteration;
			reach_q  <= item.reach;
			val_q[0] <= item.value_0;
			val_q[1] <= item.value_1;
			val_q[2] <= item.value_2;
			val_q[3] <= item.value_3;
			val_q[4] <= item.value_4;
			val_q[5] <= item.value_5;
			n_q      <= n_eff;
			err_q    <= (item.mode == MODE_AVERAGE) && (item.reach > ONE_Q15);
			unif_q   <= 1'b0;
		end else if (state_q == ST_SUM && merge_done) begin
			unif_q <= (sum <= 64'sd0);
		end
	end

	// State register and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIVST) begin
				step_q <= '0;
			end else if (state_q == ST_DIV) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	// Next state and lane control.
	always_comb begin
		state_d     = state_q;
		merge_start = 1'b0;
		ctrl        = '0;
		ctrl.mode   = mode_q;
		ctrl.shift  = shift;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.mode == MODE_AVERAGE && item.reach > ONE_Q15) begin
						state_d = ST_DONE;
					end else if (item.mode == MODE_REGRET || item.mode == MODE_AVERAGE) begin
						state_d = ST_MUL1;
					end else begin
						state_d     = ST_SUM;
						merge_start = 1'b1;
					end
				end
			end
			ST_MUL1: begin
				ctrl.mul1 = 1'b1;
				state_d   = ST_MUL2;
			end
			ST_MUL2: begin
				ctrl.mul2 = 1'b1;
				state_d   = ST_ACC;
			end
			ST_ACC: begin
				ctrl.acc = 1'b1;
				state_d  = ST_DONE;
			end
			ST_SUM: begin
				if (merge_done) begin
					state_d = (sum <= 64'sd0) ? ST_DONE : ST_DIVST;
				end
			end
			ST_DIVST: begin
				ctrl.div_start = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				ctrl.div_step = 1'b1;
				if (step_q == 4'd15) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Parallel action lanes; unused slots read as zero.
	for (genvar g = 0; g < IO_SLOTS; g++) begin : g_lane
		if (g < MAX_ACTIONS) begin : g_on
			rmu_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.active    (3'(g) < n_q),
				.iteration (iter_q),
				.reach     (reach_q),
				.value     (val_q[g]),
				.sum       (sum),
				.term      (terms[g]),
				.prob      (lane_prob[g])
			);
		end else begin : g_off
			assign terms[g]     = 64'sd0;
			assign lane_prob[g] = 17'd0;
		end
	end

	// Merge stage over the lane terms.
	rmu_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (merge_start),
		.n      (n_eff),
		.terms  (terms),
		.sum    (sum),
		.shift  (shift),
		.done   (merge_done)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			error_q <= err_q;
			for (int i = 0; i < IO_SLOTS; i++) begin
				if (err_q || mode_q == MODE_REGRET || mode_q == MODE_AVERAGE
						|| 3'(i) >= n_q) begin
					prob_q[i] <= 17'd0;
				end else if (unif_q) begin
					prob_q[i] <= uniform_q16(n_q);
				end else begin
					prob_q[i] <= lane_prob[i];
				end
			end
		end
	end

	assign result.valid  = out_valid_q;
	assign result.prob_0 = prob_q[0];
	assign result.prob_1 = prob_q[1];
	assign result.prob_2 = prob_q[2];
	assign result.prob_3 = prob_q[3];
	assign result.prob_4 = prob_q[4];
	assign result.prob_5 = prob_q[5];
	assign result.error  = error_q;

	// An accepted request always leaves the idle state.
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// Dividers only run against a positive sum.
	a_div_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> sum > 64'sd0)
		else $error("divider running with non-positive sum");

	// An error result carries no probabilities.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_q) |-> (prob_q[0] == 17'd0 && prob_q[1] == 17'd0
			&& prob_q[2] == 17'd0 && prob_q[3] == 17'd0 && prob_q[4] == 17'd0
			&& prob_q[5] == 17'd0))
		else $error("error result with nonzero probability");

endmodule

// ===== sim/tb_rmu_if.sv =====
// ----------------------------------------------------------------------------
// tb_rmu_if
// Note: the request and result channel interfaces are defined with the RTL
// (rmu_req_if, rmu_res_if). This file only holds a small helper package that
// carries the predicted result record used by the testbench.
// ----------------------------------------------------------------------------
package tb_rmu_types;
	timeunit 1ns;
	timeprecision 1ps;

	// One predicted result of the block.
	typedef struct {
		logic [16:0] prob [6];
		logic        error;
	} rmu_result_t;
endpackage

// ===== sim/tb_regret_matching_unit.sv =====
// ----------------------------------------------------------------------------
// tb_regret_matching_unit
// Self-checking testbench for the regret matching unit. A predictor keeps its
// own regret and strategy accumulators, works out the result of each accepted
// request and compares it field by field with the result the block returns.
// ----------------------------------------------------------------------------
module tb_regret_matching_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rmu_pkg::*;
	import tb_rmu_types::*;

	localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SAT_LO = 64'sh8000_0000_0000_0000;
	localparam int     CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_wdata = 3'd6;

	rmu_req_if item ();
	rmu_res_if result ();

	regret_matching_unit u_top (
		.clk(clk), .arst_n(arst_n), .item(item.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// Predictor state.
	logic [2:0] pred_count = 3'd6;
	longint regret_acc [6];
	longint strategy_acc [6];
	rmu_result_t expected_q [$];
	int mismatches = 0;
	int cycles = 0;
	bit hold_long = 1'b0;
	bit quiet_recv = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Saturating signed 64-bit add.
	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (b > 0 && s < a) return SAT_HI;
		if (b < 0 && s > a) return SAT_LO;
		return s;
	endfunction

	function automatic longint floor_shr(longint x, int s);
		return x >>> s;
	endfunction

	// Normalize terms into Q1.16 probabilities.
	function automatic void normalize(longint t [6], int n, ref logic [16:0] p [6]);
		longint sum, b, v;
		int s, i;
		bit ovf;
		logic [63:0] r, q;
		for (s = 0; s < 4; s++) begin
			ovf = 0;
			sum = 0;
			for (i = 0; i < n; i++) begin
				v = floor_shr(t[i], s);
				if ((v > 0 && sum > SAT_HI - v) || (v < 0 && sum < SAT_LO - v)) begin
					ovf = 1;
				end
				if (!ovf) sum += v;
			end
			if (!ovf) break;
		end
		if (s > 3) s = 3;
		for (i = 0; i < n; i++) begin
			b = floor_shr(t[i], s);
			if (sum <= 0) p[i] = 17'(65536 / n);
			else if (b <= 0) p[i] = '0;
			else if (b >= sum) p[i] = ONE_Q16;
			else begin
				r = b;
				q = 0;
				repeat (16) begin
					r = r << 1;
					q = q << 1;
					if (r >= sum) begin
						r -= sum;
						q[0] = 1'b1;
					end
				end
				p[i] = q[16:0];
			end
		end
	endfunction

	// Work out the result of one request and update the accumulators.
	function automatic rmu_result_t predict_request(mode_t m, logic [19:0] it,
			logic [15:0] rch, logic signed [31:0] v [6]);
		rmu_result_t r;
		longint t [6];
		longint pr, mg;
		int n, i;
		n = (pred_count == 0) ? 1 : (pred_count > 6 ? 6 : pred_count);
		for (i = 0; i < 6; i++) r.prob[i] = '0;
		r.error = 1'b0;
		case (m)
			MODE_REGRET: begin
				for (i = 0; i < n; i++)
					regret_acc[i] = sat_add(regret_acc[i], longint'(it) * longint'(v[i]));
			end
			MODE_AVERAGE: begin
				if (rch > ONE_Q15) r.error = 1'b1;
				else begin
					for (i = 0; i < n; i++) begin
						pr = longint'(rch) * longint'(v[i]);
						mg = (pr < 0 ? -pr : pr) >>> 15;
						strategy_acc[i] = sat_add(strategy_acc[i],
							longint'(it) * (pr < 0 ? -mg : mg));
					end
				end
			end
			default: begin
				for (i = 0; i < 6; i++) begin
					if (m == MODE_CURRENT) t[i] = regret_acc[i] > 0 ? regret_acc[i] : 0;
					else t[i] = strategy_acc[i];
				end
				normalize(t, n, r.prob);
			end
		endcase
		return r;
	endfunction

	// Cycle counter with timeout.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: random stalls, a few of them long, plus a long hold-off when
	// requested.
	initial begin
		int hold;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				result.ready <= 1'b0;
				for (hold = 0; hold < 3000; hold++) @(posedge clk);
				hold_long = 1'b0;
			end
			if (quiet_recv) result.ready <= 1'b1;
			else if ($urandom_range(0, 9) < 7) result.ready <= 1'b1;
			else begin
				result.ready <= 1'b0;
				if ($urandom_range(0, 19) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		rmu_result_t e;
		logic [16:0] got [6];
		bit bad;
		if (arst_n && result.valid && result.ready) begin
			got = '{result.prob_0, result.prob_1, result.prob_2,
				result.prob_3, result.prob_4, result.prob_5};
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result at cycle %0d", cycles);
			end else begin
				e = expected_q.pop_front();
				bad = (e.error !== result.error);
				for (int i = 0; i < 6; i++) if (e.prob[i] !== got[i]) bad = 1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result mismatch: exp %p err %b, got %p err %b",
							e.prob, e.error, got, result.error);
				end
			end
		end
	end

	// Send one request and record its predicted result. The task waits on the
	// clock before the request is driven, so valid never gets two
	// updates in one time step.
	task automatic send_request(mode_t m, logic [19:0] it, logic [15:0] rch,
			logic signed [31:0] v [6], bit gaps = 1);
		int g;
		rmu_result_t exp_r;
		g = 1;
		if (gaps) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
		end
		repeat (g) @(posedge clk);
		item.valid <= 1'b1;
		item.mode <= m;
		item.iteration <= it;
		item.reach <= rch;
		item.value_0 <= v[0];
		item.value_1 <= v[1];
		item.value_2 <= v[2];
		item.value_3 <= v[3];
		item.value_4 <= v[4];
		item.value_5 <= v[5];
		do @(posedge clk); while (!item.ready);
		exp_r = predict_request(m, it, rch, v);
		expected_q = {expected_q, exp_r};
		item.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_action_count(logic [2:0] n);
		wait_drained();
		cfg_wdata <= n;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		pred_count = n;
	endtask

	function automatic logic signed [31:0] rand_value(mode_t m);
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom();
			default: return (m == MODE_AVERAGE) ? 32'($urandom_range(0, 65536))
				: 32'($signed($urandom_range(0, 400000)) - 150000);
		endcase
	endfunction

	task automatic random_request();
		logic signed [31:0] v [6];
		mode_t m;
		logic [15:0] rch;
		m = mode_t'($urandom_range(0, 3));
		for (int i = 0; i < 6; i++) v[i] = rand_value(m);
		rch = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 32768));
		send_request(m, ($urandom_range(0, 7) == 0) ? 20'hFFFFF : 20'($urandom()), rch, v);
	endtask

	// Directed: extremes of every field, every mode, reach limits, saturation.
	task automatic test_directed();
		logic signed [31:0] v [6];
		v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 65536, -65536, 1};
		send_request(MODE_CURRENT, 0, 0, v);
		send_request(MODE_READAVG, 0, 0, v);
		send_request(MODE_REGRET, 20'hFFFFF, 16'hFFFF, v);
		send_request(MODE_CURRENT, 1, 0, v);
		send_request(MODE_AVERAGE, 20'hFFFFF, 16'd32768, v);
		send_request(MODE_AVERAGE, 1, 16'd32769, v);
		send_request(MODE_AVERAGE, 1, 16'hFFFF, v);
		send_request(MODE_READAVG, 0, 0, v);
		for (int k = 0; k < 12; k++) send_request(MODE_REGRET, 20'hFFFFF, 0, v);
		send_request(MODE_CURRENT, 0, 0, v);
		v = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
		for (int k = 0; k < 6; k++) send_request(MODE_AVERAGE, 20'hFFFFF, 16'd32768, v);
		send_request(MODE_READAVG, 0, 0, v);
	endtask

	task automatic test_random_counts();
		logic [2:0] counts [5] = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd6};
		foreach (counts[c]) begin
			set_action_count(counts[c]);
			repeat (120) random_request();
		end
	endtask

	// Receiver holds off while the sender keeps offering requests.
	task automatic test_backpressure();
		hold_long = 1'b1;
		repeat (40) random_request();
		wait_drained();
		quiet_recv = 1'b1;
		repeat (40) begin
			logic signed [31:0] v [6];
			for (int i = 0; i < 6; i++) v[i] = rand_value(MODE_REGRET);
			send_request(mode_t'($urandom_range(0, 3)), 20'($urandom()),
				16'($urandom_range(0, 32768)), v, 0);
		end
		quiet_recv = 1'b0;
	endtask

	initial begin
		item.valid = 1'b0;
		item.mode = MODE_REGRET;
		item.iteration = '0;
		item.reach = '0;
		item.value_0 = '0;
		item.value_1 = '0;
		item.value_2 = '0;
		item.value_3 = '0;
		item.value_4 = '0;
		item.value_5 = '0;
		foreach (regret_acc[i]) begin
			regret_acc[i] = 0;
			strategy_acc[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_counts();
		test_backpressure();
		wait_drained();
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
hw/rtl/rmu_pkg.sv
hw/rtl/rmu_req_if.sv
hw/rtl/rmu_res_if.sv
hw/rtl/rmu_lane.sv
hw/rtl/rmu_merge.sv
hw/rtl/regret_matching_unit.sv
sim/tb_rmu_if.sv
sim/tb_regret_matching_unit.sv
